FILE: sv/wbmw_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constant tables of the wedge blend weight pipeline.
// No dependencies; the stage modules, the top and the checker refer to it by scoped names.
package wbmw_pkg;

    // Wedge directions
    localparam logic [2:0] DIR_HOR  = 3'd0;
    localparam logic [2:0] DIR_VER  = 3'd1;
    localparam logic [2:0] DIR_O27  = 3'd2;
    localparam logic [2:0] DIR_O63  = 3'd3;
    localparam logic [2:0] DIR_O117 = 3'd4;
    localparam logic [2:0] DIR_O153 = 3'd5;

    // Profile selection
    localparam logic [1:0] SEL_EVEN = 2'd0;
    localparam logic [1:0] SEL_ODD  = 2'd1;
    localparam logic [1:0] SEL_VERT = 2'd2;

    localparam logic [6:0] WEIGHT_MAX = 7'd64;
    localparam logic [5:0] IDX_MAX    = 6'd63;
    localparam logic [5:0] PROF_LO    = 6'd28;
    localparam logic [5:0] PROF_HI    = 6'd36;
    localparam logic [5:0] MID        = 6'd32;
    localparam logic [5:0] SHIFT_BASE = 6'd16;

    localparam logic [2:0] BOOK_DIR [16] = '{
        DIR_O27, DIR_O63, DIR_O117, DIR_O153,
        DIR_HOR, DIR_HOR, DIR_VER,  DIR_VER,
        DIR_O27, DIR_O27, DIR_O153, DIR_O153,
        DIR_O63, DIR_O63, DIR_O117, DIR_O117
    };
    localparam logic [2:0] BOOK_XO [16] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd6,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd6, 3'd2, 3'd6
    };
    localparam logic [2:0] BOOK_YO [16] = '{
        3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd6, 3'd4, 3'd4,
        3'd2, 3'd6, 3'd2, 3'd6, 3'd4, 3'd4, 3'd4, 3'd4
    };
    // Bit n is the sign flip of wedge entry n
    localparam logic [15:0] FLIP_TAB = 16'b1011_1011_1111_1111;

    localparam logic [6:0] PROF_ODD  [8] = '{7'd1, 7'd2, 7'd6, 7'd18,
                                             7'd37, 7'd53, 7'd60, 7'd63};
    localparam logic [6:0] PROF_EVEN [8] = '{7'd1, 7'd4, 7'd11, 7'd27,
                                             7'd46, 7'd58, 7'd62, 7'd63};
    localparam logic [6:0] PROF_VERT [8] = '{7'd0, 7'd2, 7'd7, 7'd21,
                                             7'd43, 7'd57, 7'd62, 7'd64};

    typedef struct packed {
        logic [3:0] wedge_id;
        logic       invert;
        logic [1:0] width_code;
        logic [1:0] height_code;
        logic [4:0] pixel_row;
        logic [4:0] pixel_col;
    } pix_t;

    // After decode: block coordinates moved to master space
    typedef struct packed {
        logic [2:0] dir;
        logic [5:0] r;
        logic [5:0] c;
        logic       flip;
    } dec_t;

    // After mapping: profile position and final polarity
    typedef struct packed {
        logic [1:0] sel;
        logic [5:0] idx;
        logic       neg;
    } map_t;

    function automatic logic [6:0] prof_value(input logic [1:0] sel, input logic [5:0] idx);
        logic [5:0] rel;
        logic [6:0] v;
        rel = 6'(idx - PROF_LO);
        case (sel)
            SEL_EVEN: v = PROF_EVEN[rel[2:0]];
            SEL_ODD:  v = PROF_ODD[rel[2:0]];
            default:  v = PROF_VERT[rel[2:0]];
        endcase
        if (idx < PROF_LO)
            v = 7'd0;
        else if (idx >= PROF_HI)
            v = WEIGHT_MAX;
        return v;
    endfunction

endpackage

FILE: sv/wbmw_if.sv
`timescale 1ns / 1ps
// Handshake channels of the wedge blend weight block: pixel request and weight.
// No dependencies.
interface wbmw_pix_if;
    logic       valid;
    logic       ready;
    logic [3:0] wedge_id;
    logic       invert;
    logic [1:0] width_code;
    logic [1:0] height_code;
    logic [4:0] pixel_row;
    logic [4:0] pixel_col;

    modport source(output valid, wedge_id, invert, width_code, height_code,
                   pixel_row, pixel_col, input ready);
    modport sink(input valid, wedge_id, invert, width_code, height_code,
                 pixel_row, pixel_col, output ready);
endinterface

interface wbmw_wgt_if;
    logic       valid;
    logic       ready;
    logic [6:0] weight;

    modport source(output valid, weight, input ready);
    modport sink(input valid, weight, output ready);
endinterface

FILE: sv/wbmw_dec.sv
`timescale 1ns / 1ps
// Stage 1: codebook decode, block offsets and master-space row/column.
// Depends on wbmw_pkg.
module wbmw_dec
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wbmw_pkg::pix_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output wbmw_pkg::dec_t out_item
);

    logic           valid_reg;
    wbmw_pkg::dec_t item_reg;
    wbmw_pkg::dec_t item_next;
    logic [1:0]     kw;
    logic [1:0]     kh;
    logic [7:0]     woff;
    logic [7:0]     hoff;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        // size code three saturates to 32 pixels
        kw = (in_item.width_code == 2'd3) ? 2'd2 : in_item.width_code;
        kh = (in_item.height_code == 2'd3) ? 2'd2 : in_item.height_code;
        woff = 8'(wbmw_pkg::BOOK_XO[in_item.wedge_id]) << kw;
        hoff = 8'(wbmw_pkg::BOOK_YO[in_item.wedge_id]) << kh;
        item_next.dir  = wbmw_pkg::BOOK_DIR[in_item.wedge_id];
        item_next.r    = 6'(wbmw_pkg::MID - hoff[5:0] + {1'b0, in_item.pixel_row});
        item_next.c    = 6'(wbmw_pkg::MID - woff[5:0] + {1'b0, in_item.pixel_col});
        item_next.flip = in_item.invert ^ wbmw_pkg::FLIP_TAB[in_item.wedge_id];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

FILE: sv/wbmw_map.sv
`timescale 1ns / 1ps
// Stage 2: direction mapping onto the two masters, row shift and edge clamp.
// Depends on wbmw_pkg.
module wbmw_map
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wbmw_pkg::dec_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output wbmw_pkg::map_t out_item
);

    logic           valid_reg;
    wbmw_pkg::map_t item_reg;
    wbmw_pkg::map_t item_next;
    logic [5:0]     mr;
    logic [5:0]     mc;
    logic           dneg;
    logic [6:0]     mr_inc;
    logic [7:0]     pos;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        mr   = in_item.r;
        mc   = in_item.c;
        dneg = 1'b0;
        case (in_item.dir)
            wbmw_pkg::DIR_O27:
            begin
                mr = in_item.c;
                mc = in_item.r;
            end
            wbmw_pkg::DIR_O117:
            begin
                mc   = wbmw_pkg::IDX_MAX - in_item.c;
                dneg = 1'b1;
            end
            wbmw_pkg::DIR_O153:
            begin
                mr   = in_item.c;
                mc   = wbmw_pkg::IDX_MAX - in_item.r;
                dneg = 1'b1;
            end
            default:
            begin
            end
        endcase

        // oblique row mr is the profile shifted right by 16 - ((mr+1)>>1)
        mr_inc = {1'b0, mr} + 7'd1;
        pos    = {2'b00, mc} - {2'b00, wbmw_pkg::SHIFT_BASE} + {2'b00, mr_inc[6:1]};

        item_next.neg = dneg ^ in_item.flip;
        if (in_item.dir == wbmw_pkg::DIR_HOR)
        begin
            item_next.sel = wbmw_pkg::SEL_VERT;
            item_next.idx = in_item.r;
        end
        else if (in_item.dir == wbmw_pkg::DIR_VER)
        begin
            item_next.sel = wbmw_pkg::SEL_VERT;
            item_next.idx = in_item.c;
        end
        else
        begin
            item_next.sel = mr[0] ? wbmw_pkg::SEL_ODD : wbmw_pkg::SEL_EVEN;
            if (pos[7])
                item_next.idx = 6'd0;
            else if (pos[6])
                item_next.idx = wbmw_pkg::IDX_MAX;
            else
                item_next.idx = pos[5:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= item_next;
    end

endmodule

FILE: sv/wbmw_prof.sv
`timescale 1ns / 1ps
// Stage 3: profile lookup, polarity and the output register.
// Depends on wbmw_pkg.
module wbmw_prof
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  wbmw_pkg::map_t in_item,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [6:0]    weight
);

    logic       valid_reg;
    logic [6:0] weight_reg;
    logic [6:0] weight_next;
    logic [6:0] v;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign weight    = weight_reg;

    always_comb
    begin
        v = wbmw_pkg::prof_value(in_item.sel, in_item.idx);
        weight_next = in_item.neg ? 7'(wbmw_pkg::WEIGHT_MAX - v) : v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            weight_reg <= weight_next;
    end

endmodule

FILE: sv/wedge_blend_mask_weight.sv
`timescale 1ns / 1ps
// Wedge blend weight generator: one pixel request in, one 0..64 weight out.
// Depends on wbmw_pkg, wbmw_if, wbmw_dec, wbmw_map and wbmw_prof.
//
// Takes one pixel item per cycle while the output is taken; each item passes
// through three register stages (decode, direction map with row shift, profile
// lookup into the output register). The master mask is never stored; each weight
// comes from the constant profiles. Every stage holds its own valid bit and passes
// ready back, so a stall at the output backs up stage by stage and throughput
// stays at one item per cycle whenever the output is taken.
module wedge_blend_mask_weight
(
    input  logic        clk,
    input  logic        rst_n,
    wbmw_pix_if.sink    pix,
    wbmw_wgt_if.source  wgt
);

    wbmw_pkg::pix_t pix_item;
    wbmw_pkg::dec_t dec_item;
    wbmw_pkg::map_t map_item;
    logic           dec_valid;
    logic           dec_ready;
    logic           map_valid;
    logic           map_ready;

    always_comb
    begin
        pix_item.wedge_id    = pix.wedge_id;
        pix_item.invert      = pix.invert;
        pix_item.width_code  = pix.width_code;
        pix_item.height_code = pix.height_code;
        pix_item.pixel_row   = pix.pixel_row;
        pix_item.pixel_col   = pix.pixel_col;
    end

    wbmw_dec u_dec
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .in_item   (pix_item),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_item  (dec_item)
    );

    wbmw_map u_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_item   (dec_item),
        .out_valid (map_valid),
        .out_ready (map_ready),
        .out_item  (map_item)
    );

    wbmw_prof u_prof
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (map_valid),
        .in_ready  (map_ready),
        .in_item   (map_item),
        .out_valid (wgt.valid),
        .out_ready (wgt.ready),
        .weight    (wgt.weight)
    );

`ifndef ASSERT_OFF
    // input backs off only when every stage holds an item
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> (dec_valid && map_valid && wgt.valid))
        else $error("input blocked with a free stage");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        wgt.valid |-> (wgt.weight <= wbmw_pkg::WEIGHT_MAX))
        else $error("weight above 64");

    // an item moved into the last stage shows up at the output
    a_last_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (map_valid && map_ready) |=> wgt.valid)
        else $error("item lost entering output register");

    a_mid_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (dec_valid && dec_ready) |=> map_valid)
        else $error("item lost entering map stage");
`endif

endmodule

FILE: sim/wbmw_checker.sv
`timescale 1ns / 1ps
// Checker for the wedge blend weight block: watches both channels, predicts each weight.
// Depends on wbmw_pkg (types, direction codes) and wbmw_if (channel interfaces).
module wbmw_checker
(
    input  logic   clk,
    input  logic   rst_n,
    wbmw_pix_if    pix,
    wbmw_wgt_if    wgt,
    output int     errors,
    output int     pending,
    output int     checked
);

    typedef struct {
        wbmw_pkg::pix_t item;
        logic [6:0]     weight;
    } due_t;

    due_t due_weights[$];

    // Transition ramps, entries 28..35 of each 64-entry profile
    localparam logic [6:0] RAMP_ODD  [8] = '{7'd1, 7'd2, 7'd6, 7'd18,
                                             7'd37, 7'd53, 7'd60, 7'd63};
    localparam logic [6:0] RAMP_EVEN [8] = '{7'd1, 7'd4, 7'd11, 7'd27,
                                             7'd46, 7'd58, 7'd62, 7'd63};
    localparam logic [6:0] RAMP_VERT [8] = '{7'd0, 7'd2, 7'd7, 7'd21,
                                             7'd43, 7'd57, 7'd62, 7'd64};

    localparam logic [2:0] CB_DIR [16] = '{
        wbmw_pkg::DIR_O27, wbmw_pkg::DIR_O63, wbmw_pkg::DIR_O117, wbmw_pkg::DIR_O153,
        wbmw_pkg::DIR_HOR, wbmw_pkg::DIR_HOR, wbmw_pkg::DIR_VER,  wbmw_pkg::DIR_VER,
        wbmw_pkg::DIR_O27, wbmw_pkg::DIR_O27, wbmw_pkg::DIR_O153, wbmw_pkg::DIR_O153,
        wbmw_pkg::DIR_O63, wbmw_pkg::DIR_O63, wbmw_pkg::DIR_O117, wbmw_pkg::DIR_O117
    };
    localparam int CB_XO [16] = '{4, 4, 4, 4, 4, 4, 2, 6, 4, 4, 4, 4, 2, 6, 2, 6};
    localparam int CB_YO [16] = '{4, 4, 4, 4, 2, 6, 4, 4, 2, 6, 2, 6, 4, 4, 4, 4};
    localparam bit CB_FLIP [16] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1, 1, 1, 0, 1};

    function automatic logic [6:0] ramp_at(input logic [1:0] sel, input int pos);
        if (pos < 28)
            return 7'd0;
        if (pos >= 36)
            return 7'd64;
        case (sel)
            wbmw_pkg::SEL_ODD:  return RAMP_ODD[pos - 28];
            wbmw_pkg::SEL_EVEN: return RAMP_EVEN[pos - 28];
            default:            return RAMP_VERT[pos - 28];
        endcase
    endfunction

    // Oblique-63 master: row r is the ramp shifted by 16-((r+1)>>1), clamped at the edges
    function automatic logic [6:0] oblique_at(input int r, input int c);
        int pos;
        pos = c - (16 - ((r + 1) >> 1));
        if (pos < 0)
            pos = 0;
        if (pos > 63)
            pos = 63;
        return ramp_at((r % 2) ? wbmw_pkg::SEL_ODD : wbmw_pkg::SEL_EVEN, pos);
    endfunction

    function automatic int block_px(input logic [1:0] code);
        return 8 << ((code > 2) ? 2 : int'(code));
    endfunction

    function automatic logic [6:0] predict_weight(input wbmw_pkg::pix_t p);
        int         woff;
        int         hoff;
        int         r;
        int         c;
        logic [6:0] v;
        woff = (CB_XO[p.wedge_id] * block_px(p.width_code)) >> 3;
        hoff = (CB_YO[p.wedge_id] * block_px(p.height_code)) >> 3;
        r = (32 - hoff + int'(p.pixel_row)) & 63;
        c = (32 - woff + int'(p.pixel_col)) & 63;
        case (CB_DIR[p.wedge_id])
            wbmw_pkg::DIR_HOR:  v = ramp_at(wbmw_pkg::SEL_VERT, r);
            wbmw_pkg::DIR_VER:  v = ramp_at(wbmw_pkg::SEL_VERT, c);
            wbmw_pkg::DIR_O27:  v = oblique_at(c, r);
            wbmw_pkg::DIR_O63:  v = oblique_at(r, c);
            wbmw_pkg::DIR_O117: v = 7'd64 - oblique_at(r, 63 - c);
            default:            v = 7'd64 - oblique_at(c, 63 - r);
        endcase
        if (p.invert ^ CB_FLIP[p.wedge_id])
            v = 7'd64 - v;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
        checked = 0;
    end

    always @(posedge clk)
    begin
        wbmw_pkg::pix_t p;
        due_t d;
        if (rst_n)
        begin
            if (wgt.valid && wgt.ready)
            begin
                if (due_weights.size() == 0)
                    report_mismatch($sformatf("weight %0d with no item outstanding",
                                              wgt.weight));
                else
                begin
                    d = due_weights.pop_front();
                    checked++;
                    if (wgt.weight !== d.weight)
                        report_mismatch($sformatf(
                            "weight %0d, want %0d (wi %0d inv %0d w %0d h %0d r %0d c %0d)",
                            wgt.weight, d.weight, d.item.wedge_id, d.item.invert,
                            d.item.width_code, d.item.height_code,
                            d.item.pixel_row, d.item.pixel_col));
                end
            end
            if (pix.valid && pix.ready)
            begin
                p = {pix.wedge_id, pix.invert, pix.width_code, pix.height_code,
                     pix.pixel_row, pix.pixel_col};
                d.item   = p;
                d.weight = predict_weight(p);
                due_weights.push_back(d);
            end
            pending = due_weights.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// Top of the wedge blend weight testbench: clock, reset, pixel stimulus, output stalls.
// Depends on wbmw_if, wedge_blend_mask_weight and wbmw_checker.
module testbench;

    localparam int RANDOM_ITEMS = 1630;
    localparam int STALL_LIMIT  = 2000;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int checked;
    int sent = 0;
    int idle_cycles = 0;
    bit steady = 1'b0;

    wbmw_pix_if pix();
    wbmw_wgt_if wgt();

    wedge_blend_mask_weight DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .wgt   (wgt)
    );

    wbmw_checker u_checker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix     (pix),
        .wgt     (wgt),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    always #10 clk = ~clk;

    // In steady stretches neither side idles
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic send_pixel(input logic [3:0] wi, input logic inv, input logic [1:0] wc,
                              input logic [1:0] hc, input logic [4:0] row,
                              input logic [4:0] col);
        int gap;
        bit taken;
        gap = draw_gap();
        if (gap > 0)
        begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.wedge_id    <= wi;
        pix.invert      <= inv;
        pix.width_code  <= wc;
        pix.height_code <= hc;
        pix.pixel_row   <= row;
        pix.pixel_col   <= col;
        // ready is sampled mid-cycle, once inputs and pipeline have settled
        do
        begin
            @(negedge clk);
            taken = pix.ready;
            @(posedge clk);
        end
        while (!taken);
        sent++;
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        pix.valid       <= 1'b0;
        pix.wedge_id    <= '0;
        pix.invert      <= 1'b0;
        pix.width_code  <= '0;
        pix.height_code <= '0;
        pix.pixel_row   <= '0;
        pix.pixel_col   <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every codebook entry, both polarities, all size codes including the saturating one
        for (int i = 0; i < 16; i++)
            send_pixel(4'(i), i[0], 2'(i % 4), 2'((i / 4) % 4), 5'((i * 7) % 32),
                       5'((i * 13) % 32));
        send_pixel(4'd0,  1'b0, 2'd0, 2'd0, 5'd0,  5'd0);
        send_pixel(4'd15, 1'b1, 2'd3, 2'd3, 5'd31, 5'd31);
        send_pixel(4'd10, 1'b0, 2'd0, 2'd2, 5'd31, 5'd0);   // tall block, pixel in its last row
        send_pixel(4'd14, 1'b1, 2'd2, 2'd0, 5'd0,  5'd31);  // wide block, pixel in its last column
        send_pixel(4'd5,  1'b1, 2'd0, 2'd0, 5'd31, 5'd31);
        send_pixel(4'd6,  1'b0, 2'd3, 2'd1, 5'd16, 5'd8);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_pixel(4'($urandom), 1'($urandom), 2'($urandom), 2'($urandom),
                       5'($urandom), 5'($urandom));
        end
        pix.valid <= 1'b0;

        @(negedge clk);
        wait (pending == 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d pixel items over all wedge indices and size codes;", sent);
        $display("%0d weights compared against the predicted mask.", checked);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Output side: random stall before taking each weight
    initial
    begin
        int  stall;
        bit  taken;
        wgt.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                wgt.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            wgt.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                taken = wgt.valid;
                @(posedge clk);
            end
            while (!taken);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix.valid && pix.ready) || (wgt.valid && wgt.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
